@@ rtl/lse_pkg.sv @@
// Shared types, constants and helper functions for the Lobatto shape function evaluator.
// Used by lse_tables, lse_mul and lobatto_shape_function_eval; depends on nothing else.
package lse_pkg;

   localparam int MAX_DEGREE  = 10;
   localparam int FRAC_BITS   = 16;
   localparam int POINT_W     = 18;
   localparam int VAL_W       = 18;
   localparam int SLOPE_W     = 20;
   localparam int DEG_W       = 6;
   localparam int MODE_W      = 2;
   localparam int LEG_W       = FRAC_BITS + 8;
   localparam int COEF_BITS   = 28;
   localparam int COEF_W      = 32;
   localparam int COEF_DEPTH  = 1 << DEG_W;
   localparam int CLAMP_BITS  = 22;
   localparam int OPND_W      = 33;
   localparam int PROD_W      = 2 * OPND_W;
   localparam int WIDE_W      = PROD_W + 2;
   localparam int T_W         = 35;
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = 32;
   localparam int DIVN_W      = 31;
   localparam int DIVR_W      = 7;
   localparam int DIVR_DEPTH  = 1 << DIVR_W;

   localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd2;

   typedef logic signed [WIDE_W-1:0]  wide_type;
   typedef logic signed [OPND_W-1:0]  opnd_type;
   typedef logic signed [PROD_W-1:0]  prod_type;

   localparam wide_type ONE_WIDE  = WIDE_W'(1) <<< FRAC_BITS;
   localparam wide_type OPND_LIM  = WIDE_W'(1) <<< CLAMP_BITS;
   // Dividend magnitudes above this bound saturate the quotient anyway.
   localparam wide_type DIVN_LIM  = (WIDE_W'(1) <<< (DIVN_W - 1)) - WIDE_W'(1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HAT0,
      ST_HAT1,
      ST_KM,
      ST_KMC,
      ST_IP,
      ST_NUM,
      ST_DIVQ,
      ST_DIVC,
      ST_SLOPE,
      ST_VALN,
      ST_VALQ,
      ST_VALC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      opnd_type a;
      opnd_type b;
   } mul_req_type;

   function automatic wide_type clamp_wide(input wide_type v, input wide_type lim);
      wide_type r;
      r = v;
      if (v < -lim) r = -lim;
      if (v > lim) r = lim;
      return r;
   endfunction

   function automatic wide_type sat_wide(input wide_type v, input int bits);
      wide_type hi;
      wide_type r;
      hi = (WIDE_W'(1) <<< (bits - 1)) - WIDE_W'(1);
      r = v;
      if (v < -hi - WIDE_W'(1)) r = -hi - WIDE_W'(1);
      if (v > hi) r = hi;
      return r;
   endfunction

   function automatic wide_type abs_wide(input wide_type v);
      return (v < 0) ? -v : v;
   endfunction

   // Arithmetic right shift that rounds to nearest, halves away from zero.
   function automatic wide_type rnd_shr(input wide_type v, input int sh);
      wide_type mag;
      wide_type q;
      mag = abs_wide(v);
      q = (mag + (WIDE_W'(1) <<< (sh - 1))) >>> sh;
      return (v < 0) ? -q : q;
   endfunction

   function automatic logic signed [VAL_W-1:0] sat_val(input wide_type v);
      wide_type c;
      c = sat_wide(clamp_wide(v, ONE_WIDE), VAL_W);
      return c[VAL_W-1:0];
   endfunction

   // Integer square root rounded to nearest; evaluated only at elaboration.
   function automatic logic [63:0] isqrt_round(input logic [63:0] a);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bt;
      rem = a;
      res = '0;
      bt  = 64'd1 << 62;
      for (int s = 0; s < 32; s++) begin
         if (rem >= res + bt) begin
            rem = rem - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      if (rem > res) res = res + 64'd1;
      return res;
   endfunction

endpackage

@@ rtl/lse_tables.sv @@
// Constant lookup tables: reciprocals floor(2^32/d) for the divider and
// norm factors sqrt((2i+1)/2) in Q28. Depends on lse_pkg.
module lse_tables (
   input  logic [lse_pkg::DIVR_W-1:0]  divisor,
   input  logic [lse_pkg::DEG_W-1:0]   coef_sel,
   output logic [lse_pkg::RECIP_W-1:0] recip,
   output logic [lse_pkg::COEF_W-1:0]  coef
);
   import lse_pkg::*;

   logic [RECIP_W-1:0] recip_rom [DIVR_DEPTH];
   logic [COEF_W-1:0]  coef_rom  [COEF_DEPTH];

   for (genvar g = 0; g < DIVR_DEPTH; g++) begin : g_recip
      localparam logic [63:0] RecipFull =
         (64'd1 << RECIP_SHIFT) / 64'((g < 2) ? 2 : g);
      assign recip_rom[g] = (g < 2) ? '0 : RecipFull[RECIP_W-1:0];
   end

   for (genvar g = 0; g < COEF_DEPTH; g++) begin : g_coef
      localparam logic [63:0] CoefFull =
         isqrt_round(64'(2 * g + 1) << (2 * COEF_BITS - 1));
      assign coef_rom[g] = CoefFull[COEF_W-1:0];
   end

   assign recip = recip_rom[divisor];
   assign coef  = coef_rom[coef_sel];

endmodule

@@ rtl/lse_mul.sv @@
// Shared signed multiplier with a registered product, one operation per cycle.
// Depends on lse_pkg.
module lse_mul (
   input  logic                 clock,
   input  lse_pkg::mul_req_type mul_req,
   output lse_pkg::prod_type    prod
);
   import lse_pkg::*;

   prod_type prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_req.a) * PROD_W'(mul_req.b);
   end

   assign prod = prod_ff;

endmodule

@@ rtl/lobatto_shape_function_eval.sv @@
// Top level of the Lobatto shape function evaluator: sequencer, datapath registers
// and output register. Depends on lse_pkg, lse_tables and lse_mul.
//
//   Channel   Ports          Direction  Carries
//   req       req_*          in         point x, signed Q16
//   rsp       rsp_*          out        degree, shape value, shape slope, last
//   csr       csr_wr_*       in         domain_mode register
//
// One item yields MAX_DEGREE+1 results and occupies the block from acceptance until
// its last result is emitted, so a new item is taken only once the sequencer is idle.
// The schedule is set by the shared multiplier: eleven steps per degree, nine of them
// multiplier passes for the recurrence products, two reciprocal divisions and the norm
// scaling, then the quotient correction and the emit. Reset is synchronous and clears
// the sequencer. An output stall holds the sequencer at the next result until the
// register frees.
module lobatto_shape_function_eval (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [lse_pkg::MODE_W-1:0]          csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [lse_pkg::POINT_W-1:0]  req_point,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lse_pkg::DEG_W-1:0]           rsp_degree,
   output logic signed [lse_pkg::VAL_W-1:0]    rsp_shape_value,
   output logic signed [lse_pkg::SLOPE_W-1:0]  rsp_shape_slope,
   output logic                                rsp_last
);
   import lse_pkg::*;

   state_type                  state_ff, state_in;
   logic [MODE_W-1:0]          mode_ff;
   logic signed [POINT_W-1:0]  m_ff, m_in;
   logic signed [LEG_W-1:0]    prev_ff, prev_in;
   logic signed [LEG_W-1:0]    curr_ff, curr_in;
   logic signed [LEG_W-1:0]    next_ff, next_in;
   logic [DEG_W-1:0]           deg_ff, deg_in;
   logic signed [T_W-1:0]      t_ff, t_in;
   logic [DIVN_W-1:0]          num_ff, num_in;
   logic [DIVN_W-1:0]          q0_ff, q0_in;
   logic                       sign_ff, sign_in;
   logic signed [SLOPE_W-1:0]  slope_ff, slope_in;
   logic signed [VAL_W-1:0]    val_ff, val_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [DEG_W-1:0]           rsp_degree_ff, rsp_degree_in;
   logic signed [VAL_W-1:0]    rsp_value_ff, rsp_value_in;
   logic signed [SLOPE_W-1:0]  rsp_slope_ff, rsp_slope_in;
   logic                       rsp_last_ff, rsp_last_in;

   mul_req_type                mul_req;
   prod_type                   prod;
   wide_type                   prod_w;
   logic [DIVR_W-1:0]          k_idx;
   logic [DIVR_W-1:0]          d_idx;
   logic [DIVR_W-1:0]          div_sel;
   logic [RECIP_W-1:0]         recip;
   logic [COEF_W-1:0]          coef;
   logic                       out_free;
   wide_type                   map_w;
   wide_type                   map_sat;
   wide_type                   m_w;
   wide_type                   diff_n;
   wide_type                   mag;
   wide_type                   lim;
   wide_type                   n2;
   logic [DIVN_W-1:0]          num_n;
   logic [DIVN_W:0]            rem_u;
   logic [DIVN_W-1:0]          quo_u;
   wide_type                   quo_w;
   wide_type                   quo_s;
   wide_type                   next_s;

   lse_tables u_tables (
      .divisor  (div_sel),
      .coef_sel (deg_ff),
      .recip    (recip),
      .coef     (coef)
   );

   lse_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   assign prod_w   = WIDE_W'(prod);
   assign m_w      = WIDE_W'(m_ff);
   assign k_idx    = DIVR_W'({deg_ff, 1'b1});
   assign d_idx    = DIVR_W'(deg_ff) + DIVR_W'(1);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // The value divisions use 2i+1, the recurrence divisions use i+1.
   assign div_sel = (state_ff == ST_VALN || state_ff == ST_VALQ || state_ff == ST_VALC) ?
                    k_idx : d_idx;

   always_comb begin
      case (mode_ff)
         MODE_LEFT:  map_w = rnd_shr(WIDE_W'(req_point) - ONE_WIDE, 1);
         MODE_RIGHT: map_w = rnd_shr(WIDE_W'(req_point) + ONE_WIDE, 1);
         default:    map_w = WIDE_W'(req_point);
      endcase
      map_sat = sat_wide(map_w, POINT_W);
   end

   // Reciprocal quotient correction, shared by both divisions.
   always_comb begin
      rem_u  = {1'b0, num_ff} - prod[DIVN_W:0];
      quo_u  = q0_ff + DIVN_W'(rem_u >= (DIVN_W + 1)'(div_sel));
      quo_w  = WIDE_W'(quo_u);
      quo_s  = sign_ff ? -quo_w : quo_w;
      next_s = sat_wide(quo_s, LEG_W);
   end

   always_comb begin
      state_in      = state_ff;
      m_in          = m_ff;
      prev_in       = prev_ff;
      curr_in       = curr_ff;
      next_in       = next_ff;
      deg_in        = deg_ff;
      t_in          = t_ff;
      num_in        = num_ff;
      q0_in         = q0_ff;
      sign_in       = sign_ff;
      slope_in      = slope_ff;
      val_in        = val_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_degree_in = rsp_degree_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_slope_in  = rsp_slope_ff;
      rsp_last_in   = rsp_last_ff;
      mul_req       = '0;
      diff_n        = '0;
      mag           = '0;
      lim           = '0;
      n2            = '0;
      num_n         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               m_in     = map_sat[POINT_W-1:0];
               prev_in  = ONE_WIDE[LEG_W-1:0];
               curr_in  = map_sat[LEG_W-1:0];
               deg_in   = DEG_W'(1);
               state_in = ST_HAT0;
            end
         end
         ST_HAT0: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_degree_in = '0;
               rsp_value_in  = sat_val(rnd_shr(ONE_WIDE - m_w, 1));
               rsp_slope_in  = SLOPE_W'(-(ONE_WIDE >>> 1));
               rsp_last_in   = 1'b0;
               state_in      = ST_HAT1;
            end
         end
         ST_HAT1: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_degree_in = DEG_W'(1);
               rsp_value_in  = sat_val(rnd_shr(ONE_WIDE + m_w, 1));
               rsp_slope_in  = SLOPE_W'(ONE_WIDE >>> 1);
               rsp_last_in   = (DEG_W'(1) == DEG_W'(MAX_DEGREE));
               state_in      = ST_KM;
            end
         end
         ST_KM: begin
            mul_req.a = OPND_W'(k_idx);
            mul_req.b = OPND_W'(m_ff);
            state_in  = ST_KMC;
         end
         ST_KMC: begin
            mul_req.a = prod[OPND_W-1:0];
            mul_req.b = OPND_W'(curr_ff);
            state_in  = ST_IP;
         end
         ST_IP: begin
            t_in      = T_W'(rnd_shr(prod_w, FRAC_BITS));
            mul_req.a = OPND_W'(deg_ff);
            mul_req.b = OPND_W'(prev_ff);
            state_in  = ST_NUM;
         end
         ST_NUM: begin
            // Dividend of the recurrence: t - i*P[i-1], rounded by adding d/2.
            diff_n    = WIDE_W'(t_ff) - prod_w;
            mag       = abs_wide(diff_n);
            lim       = (mag > DIVN_LIM) ? DIVN_LIM : mag;
            num_n     = DIVN_W'(lim + WIDE_W'(d_idx >> 1));
            sign_in   = diff_n[WIDE_W-1];
            num_in    = num_n;
            mul_req.a = OPND_W'(num_n);
            mul_req.b = OPND_W'(recip);
            state_in  = ST_DIVQ;
         end
         ST_DIVQ: begin
            q0_in     = prod[RECIP_SHIFT +: DIVN_W];
            mul_req.a = OPND_W'(prod[RECIP_SHIFT +: DIVN_W]);
            mul_req.b = OPND_W'(d_idx);
            state_in  = ST_DIVC;
         end
         ST_DIVC: begin
            next_in   = next_s[LEG_W-1:0];
            mul_req.a = OPND_W'(clamp_wide(WIDE_W'(curr_ff), OPND_LIM));
            mul_req.b = OPND_W'(coef);
            state_in  = ST_SLOPE;
         end
         ST_SLOPE: begin
            slope_in  = SLOPE_W'(sat_wide(rnd_shr(prod_w, COEF_BITS), SLOPE_W));
            mul_req.a = OPND_W'(clamp_wide(WIDE_W'(next_ff) - WIDE_W'(prev_ff), OPND_LIM));
            mul_req.b = OPND_W'(coef);
            state_in  = ST_VALN;
         end
         ST_VALN: begin
            // Divide by (2i+1)*2^28: round and shift first, then divide by 2i+1.
            mag       = abs_wide(prod_w);
            n2        = (mag + (WIDE_W'(k_idx) <<< (COEF_BITS - 1))) >>> COEF_BITS;
            num_n     = DIVN_W'(n2);
            sign_in   = prod_w[WIDE_W-1];
            num_in    = num_n;
            mul_req.a = OPND_W'(num_n);
            mul_req.b = OPND_W'(recip);
            state_in  = ST_VALQ;
         end
         ST_VALQ: begin
            q0_in     = prod[RECIP_SHIFT +: DIVN_W];
            mul_req.a = OPND_W'(prod[RECIP_SHIFT +: DIVN_W]);
            mul_req.b = OPND_W'(k_idx);
            state_in  = ST_VALC;
         end
         ST_VALC: begin
            val_in   = sat_val(quo_s);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_degree_in = deg_ff + DEG_W'(1);
               rsp_value_in  = val_ff;
               rsp_slope_in  = slope_ff;
               rsp_last_in   = (deg_ff + DEG_W'(1) == DEG_W'(MAX_DEGREE));
               prev_in       = curr_ff;
               curr_in       = next_ff;
               deg_in        = deg_ff + DEG_W'(1);
               if (deg_ff + DEG_W'(1) == DEG_W'(MAX_DEGREE)) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_KM;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         m_ff         <= '0;
         prev_ff      <= '0;
         curr_ff      <= '0;
         deg_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         m_ff         <= m_in;
         prev_ff      <= prev_in;
         curr_ff      <= curr_in;
         deg_ff       <= deg_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      next_ff       <= next_in;
      t_ff          <= t_in;
      num_ff        <= num_in;
      q0_ff         <= q0_in;
      sign_ff       <= sign_in;
      slope_ff      <= slope_in;
      val_ff        <= val_in;
      rsp_degree_ff <= rsp_degree_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_slope_ff  <= rsp_slope_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_degree      = rsp_degree_ff;
   assign rsp_shape_value = rsp_value_ff;
   assign rsp_shape_slope = rsp_slope_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

@@ bench/shape_result_checker.sv @@
`timescale 1ns / 1ps
// Result checker for lobatto_shape_function_eval. It follows domain_mode writes, predicts
// the shape value and slope of every degree for each accepted point, and compares in order.
// Depends on lse_pkg.
module shape_result_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [lse_pkg::MODE_W-1:0]          csr_wr_data,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [lse_pkg::POINT_W-1:0]  req_point,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [lse_pkg::DEG_W-1:0]           rsp_degree,
   input  logic signed [lse_pkg::VAL_W-1:0]    rsp_shape_value,
   input  logic signed [lse_pkg::SLOPE_W-1:0]  rsp_shape_slope,
   input  logic                                rsp_last,
   output int                                  mismatches,
   output int                                  shapes_left,
   output int                                  shapes_seen
);
   import lse_pkg::*;

   typedef struct packed {
      logic [DEG_W-1:0]   degree;
      logic [VAL_W-1:0]   value;
      logic [SLOPE_W-1:0] slope;
      logic               last;
   } shape_type;

   shape_type         expected_shapes[$];
   logic [MODE_W-1:0] mode_shadow;

   // Division rounding to nearest with halves away from zero; d is positive.
   function automatic longint round_div(input longint n, input longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint sat_to(input longint v, input int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      return clip(v, -hi - 1, hi);
   endfunction

   // sqrt(k/2) in Q28, rounded to nearest: the root of k * 2^55 found bit by bit.
   function automatic longint norm_coef(input longint k);
      longint unsigned a;
      longint unsigned r;
      longint unsigned t;
      a = longint'(k) << 55;
      r = 0;
      for (int b = 30; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= a) r = t;
      end
      if (a - r * r > r) r = r + 1;
      return longint'(r);
   endfunction

   function automatic shape_type make_shape(input int deg, input longint val,
                                            input longint slope);
      shape_type s;
      longint one;
      one = longint'(1) <<< FRAC_BITS;
      s.degree = DEG_W'(deg);
      s.value  = VAL_W'(sat_to(clip(val, -one, one), VAL_W));
      s.slope  = SLOPE_W'(sat_to(slope, SLOPE_W));
      s.last   = (deg == MAX_DEGREE);
      return s;
   endfunction

   task automatic predict_shapes(input logic signed [POINT_W-1:0] point,
                                 input logic [MODE_W-1:0] mode);
      longint one, x, m, prev, curr, k, t, next, c, diff, pc, lim, val, slope;
      one = longint'(1) <<< FRAC_BITS;
      lim = longint'(1) <<< CLAMP_BITS;
      x = point;
      if (mode == MODE_LEFT) m = round_div(x - one, 2);
      else if (mode == MODE_RIGHT) m = round_div(x + one, 2);
      else m = x;
      m = sat_to(m, POINT_W);
      // The two hat functions have fixed slopes of minus and plus one half.
      expected_shapes.push_back(make_shape(0, round_div(one - m, 2), -(one >>> 1)));
      expected_shapes.push_back(make_shape(1, round_div(one + m, 2), one >>> 1));
      prev = sat_to(one, LEG_W);
      curr = sat_to(m, LEG_W);
      for (int i = 1; i < MAX_DEGREE; i++) begin
         k = 2 * longint'(i) + 1;
         t = round_div(k * m * curr, one);
         next = sat_to(round_div(t - longint'(i) * prev, longint'(i) + 1), LEG_W);
         c = norm_coef(k);
         diff = clip(next - prev, -lim, lim);
         pc = clip(curr, -lim, lim);
         val = round_div(diff * c, k <<< COEF_BITS);
         slope = round_div(pc * c, longint'(1) <<< COEF_BITS);
         expected_shapes.push_back(make_shape(i + 1, val, slope));
         prev = curr;
         curr = next;
      end
   endtask

   always @(posedge clock) begin : watch
      shape_type got;
      shape_type want;
      if (reset) begin
         mode_shadow = '0;
         mismatches = 0;
         shapes_seen = 0;
         expected_shapes.delete();
      end else begin
         if (req_valid && !req_stall) predict_shapes(req_point, mode_shadow);
         if (rsp_valid && !rsp_stall) begin
            shapes_seen++;
            got.degree = rsp_degree;
            got.value = rsp_shape_value;
            got.slope = rsp_shape_slope;
            got.last = rsp_last;
            if (expected_shapes.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result: degree %0d value %0d slope %0d last %0d",
                           got.degree, $signed(got.value), $signed(got.slope), got.last);
               mismatches++;
            end else begin
               want = expected_shapes.pop_front();
               if (got != want) begin
                  if (mismatches < 10)
                     $display({"mismatch: expected degree %0d value %0d slope %0d last %0d,",
                               " got degree %0d value %0d slope %0d last %0d"},
                              want.degree, $signed(want.value), $signed(want.slope),
                              want.last, got.degree, $signed(got.value),
                              $signed(got.slope), got.last);
                  mismatches++;
               end
            end
         end
         // A write is only issued while the block is idle, so it applies to later points.
         if (csr_wr_en) mode_shadow = csr_wr_data;
      end
      shapes_left = expected_shapes.size();
   end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Top of the lobatto_shape_function_eval bench: clock, reset, point and mode stimulus,
// output flow control and verdict. Depends on lse_pkg, the DUT and shape_result_checker.
module testbench;
   import lse_pkg::*;

   localparam logic [MODE_W-1:0] MODE_FULL  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam int LIMIT_CYCLES = 600000;
   localparam int DRAIN_CYCLES = 2 * (2 + 11 * (MAX_DEGREE - 1));
   localparam int HOLD_CYCLES = 1000;
   localparam int PHASE_POINTS = 36;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_wr_en = 1'b0;
   logic [MODE_W-1:0]           csr_wr_data = '0;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [POINT_W-1:0]   req_point = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [DEG_W-1:0]            rsp_degree;
   logic signed [VAL_W-1:0]     rsp_shape_value;
   logic signed [SLOPE_W-1:0]   rsp_shape_slope;
   logic                        rsp_last;

   int   sender_idle_pct = 0;
   int   receiver_stall_pct = 0;
   logic hold_off = 1'b0;
   int   points_sent = 0;
   int   cycle_count = 0;
   int   mismatches;
   int   shapes_left;
   int   shapes_seen;

   int   idle_mix[4] = '{0, 66, 0, 7};
   int   stall_mix[4] = '{0, 0, 66, 7};
   int   edge_points[4] = '{65536, -65536, -131072, 131071};
   int   full_points[5] = '{0, 1, -1, 32768, -32768};

   lobatto_shape_function_eval DUT (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_point(req_point),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_degree(rsp_degree),
      .rsp_shape_value(rsp_shape_value),
      .rsp_shape_slope(rsp_shape_slope),
      .rsp_last(rsp_last)
   );

   shape_result_checker u_checker (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_point(req_point),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_degree(rsp_degree),
      .rsp_shape_value(rsp_shape_value),
      .rsp_shape_slope(rsp_shape_slope),
      .rsp_last(rsp_last),
      .mismatches(mismatches),
      .shapes_left(shapes_left),
      .shapes_seen(shapes_seen)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(99) < receiver_stall_pct);
   end

   task automatic offer_point(input logic signed [POINT_W-1:0] p);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_point = p;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      points_sent++;
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (shapes_left != 0) @(negedge clock);
   endtask

   task automatic write_mode(input logic [MODE_W-1:0] m);
      csr_wr_data = m;
      csr_wr_en = 1'b1;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Blocks the result side long enough for the block to back up onto its input.
   task automatic hold_results();
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   endtask

   function automatic logic signed [POINT_W-1:0] pick_point();
      case ($urandom_range(9))
         0: return POINT_W'($urandom);
         1: return POINT_W'(edge_points[$urandom_range(1)]);
         2: return POINT_W'(int'($urandom_range(64)) - 32);
         default: return POINT_W'(int'($urandom_range(131072)) - 65536);
      endcase
   endfunction

   initial begin
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed points: interval ends, center, points just off zero and the field extremes.
      write_mode(MODE_FULL);
      foreach (full_points[i]) offer_point(POINT_W'(full_points[i]));
      foreach (edge_points[i]) offer_point(POINT_W'(edge_points[i]));
      settle();
      write_mode(MODE_LEFT);
      foreach (edge_points[i]) offer_point(POINT_W'(edge_points[i]));
      settle();
      write_mode(MODE_RIGHT);
      foreach (edge_points[i]) offer_point(POINT_W'(edge_points[i]));
      settle();
      write_mode(MODE_SPARE);
      offer_point(POINT_W'(65536));
      offer_point(POINT_W'(-65536));
      offer_point(POINT_W'(12345));

      for (int ph = 0; ph < 8; ph++) begin
         settle();
         write_mode(MODE_W'((ph + ph / 4) % 4));
         sender_idle_pct = idle_mix[ph % 4];
         receiver_stall_pct = stall_mix[ph % 4];
         for (int n = 0; n < PHASE_POINTS; n++) begin
            if (ph == 0 && n == 5) fork hold_results(); join_none
            offer_point(pick_point());
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("%0d points checked as %0d shape results in all four domain modes,",
               points_sent, shapes_seen);
      $display("with idle and stall mixes and one long output hold-off that filled the block.");
      if (mismatches == 0 && shapes_left == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
